// ----- rtl/qrms_pkg.sv -----
// Shared constants, types and character classing for the QR mode segmenter.
`timescale 1ns / 1ps
package qrms_pkg;

   localparam int WIN     = 20;
   localparam int MAX_LEN = 8192;
   localparam int FILL_W  = $clog2(WIN + 1);
   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int CHAR_W  = 16;

   localparam logic [1:0] M_NUM   = 2'd0;
   localparam logic [1:0] M_ALNUM = 2'd1;
   localparam logic [1:0] M_BYTE  = 2'd2;
   localparam logic [1:0] M_KANJI = 2'd3;

   localparam logic [2:0] OVR_AUTO  = 3'd0;
   localparam logic [2:0] OVR_NUM   = 3'd1;
   localparam logic [2:0] OVR_ALNUM = 3'd2;
   localparam logic [2:0] OVR_BYTE  = 3'd3;
   localparam logic [2:0] OVR_KANJI = 3'd4;

   localparam logic REG_VERSION  = 1'b0;
   localparam logic REG_OVERRIDE = 1'b1;

   typedef struct packed {
      logic              clear;
      logic              shift;
      logic              load;
      logic [FILL_W-1:0] load_idx;
      logic [CHAR_W-1:0] load_char;
   } win_ctl_type;

   typedef struct packed {
      logic [1:0]        k0;
      logic [1:0]        k1;
      logic [FILL_W-1:0] run_num;
      logic [FILL_W-1:0] run_alnum;
      logic [FILL_W-1:0] run_kanji;
      logic [1:0]        kt_num;
      logic [1:0]        kt_alnum;
   } win_info_type;

   function automatic logic is_kanji(input logic [15:0] c);
      logic [7:0] hi;
      logic [7:0] lo;
      logic t1, t2, l1, l2;
      hi = c[15:8];
      lo = c[7:0];
      t1 = (lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'h80 && lo <= 8'hFC);
      t2 = (lo >= 8'h40 && lo <= 8'h7E) || (lo >= 8'h80 && lo <= 8'hBF);
      l1 = (hi >= 8'hE0 && hi <= 8'hEA) || (hi >= 8'h81 && hi <= 8'h9F);
      l2 = (hi >= 8'hEA && hi <= 8'hEB);
      return (l1 && t1) || (l2 && t2);
   endfunction

   function automatic logic [1:0] class_of(input logic [15:0] c);
      logic [1:0] k;
      if (c >= 16'h30 && c <= 16'h39) begin
         k = M_NUM;
      end else if (c == 16'h20 || c == 16'h24 || c == 16'h25 || c == 16'h2A ||
                   c == 16'h2B || c == 16'h3A || (c >= 16'h2D && c <= 16'h2F) ||
                   (c >= 16'h41 && c <= 16'h5A)) begin
         k = M_ALNUM;
      end else if (is_kanji(c)) begin
         k = M_KANJI;
      end else begin
         k = M_BYTE;
      end
      return k;
   endfunction

endpackage

// ----- rtl/qrms_cell.sv -----
// One window cell: holds a character, takes its neighbour's on a shift.
`timescale 1ns / 1ps
module qrms_cell (
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        shift,
   input  logic        load,
   input  logic [15:0] next_char,
   input  logic [15:0] load_char,
   output logic [15:0] char_q,
   output logic [1:0]  cls
);
   import qrms_pkg::*;

   logic [15:0] char_ff;
   logic [15:0] char_in;

   always_comb begin
      char_in = char_ff;
      if (clear) begin
         char_in = '0;
      end else if (shift) begin
         char_in = next_char;
      end else if (load) begin
         char_in = load_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else begin
         char_ff <= char_in;
      end
   end

   assign char_q = char_ff;
   assign cls    = class_of(char_ff);

endmodule

// ----- rtl/qrms_window.sv -----
// Lookahead window: a chain of cells with run lengths measured from the head.
`timescale 1ns / 1ps
module qrms_window (
   input  logic                  clock,
   input  logic                  reset,
   input  qrms_pkg::win_ctl_type ctl,
   output qrms_pkg::win_info_type info
);
   import qrms_pkg::*;

   logic [15:0] cell_char [WIN];
   logic [1:0]  cell_cls  [WIN];

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      logic [15:0] nxt;
      if (i == WIN - 1) begin : g_tail
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_char[i+1];
      end
      qrms_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (ctl.clear),
         .shift     (ctl.shift),
         .load      (ctl.load && (ctl.load_idx == FILL_W'(i))),
         .next_char (nxt),
         .load_char (ctl.load_char),
         .char_q    (cell_char[i]),
         .cls       (cell_cls[i])
      );
   end

   function automatic logic [FILL_W-1:0] run_len(input logic [WIN-1:0] m);
      logic [FILL_W-1:0] n;
      logic              stop;
      n    = FILL_W'(WIN);
      stop = 1'b0;
      for (int j = 0; j < WIN; j++) begin
         if (!stop && !m[j]) begin
            n    = FILL_W'(j);
            stop = 1'b1;
         end
      end
      return n;
   endfunction

   logic [WIN-1:0] m_num, m_alnum, m_kanji;

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         m_num[j]   = (cell_cls[j] == M_NUM);
         m_alnum[j] = (cell_cls[j] == M_ALNUM);
         m_kanji[j] = (cell_cls[j] == M_KANJI);
      end
   end

   always_comb begin
      info.k0        = cell_cls[0];
      info.k1        = cell_cls[1];
      info.run_num   = run_len(m_num);
      info.run_alnum = run_len(m_alnum);
      info.run_kanji = run_len(m_kanji);
      info.kt_num    = (info.run_num >= FILL_W'(WIN)) ? M_BYTE : cell_cls[info.run_num];
      info.kt_alnum  = (info.run_alnum >= FILL_W'(WIN)) ? M_BYTE : cell_cls[info.run_alnum];
   end

endmodule

// ----- rtl/qr_mode_segmenter.sv -----
// Top level of the QR mode segmenter: string state, mode decisions and result beat.
// Strings arrive one character beat at a time and leave as (start, end, mode) segment beats.
// An ordinary character beat is loaded into the twenty-entry lookahead window; then, once
// the window is full, a decision on the window head is taken, which may emit a segment. The
// beat that first fills the window in automatic mode also passes through the initial mode
// choice and then the scan of the head. The beat carrying is_final is loaded, then passes
// the decision state, the initial mode choice when none has been made, a scan of each
// character left in the window (up to twenty) and the closing segment. A forced mode or a
// string wholly in one class ends with its segment in the decision state. Any cycle that
// must emit waits while the result register is full and stalled.
`timescale 1ns / 1ps
module qr_mode_segmenter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_character,
   input  logic        req_is_final,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [13:0] rsp_seg_start,
   output logic [13:0] rsp_seg_end,
   output logic [1:0]  rsp_seg_mode,
   output logic        rsp_bad_override,
   output logic        rsp_seg_last
);
   import qrms_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_PROC, ST_INIT, ST_SCAN, ST_FINAL} state_type;

   state_type         state_ff, state_in;
   logic              fin_ff, fin_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  begin_ff, begin_in;
   logic [1:0]        mode_ff, mode_in;
   logic [3:0]        seen_ff, seen_in;
   logic              chosen_ff, chosen_in;
   logic [5:0]        version_ff;
   logic [2:0]        override_ff;
   logic              rv_ff, rv_in;
   logic [13:0]       rs_ff, rs_in, re_ff, re_in;
   logic [1:0]        rm_ff, rm_in;
   logic              rb_ff, rb_in, rl_ff, rl_in;

   win_ctl_type  ctl;
   win_info_type info;

   qrms_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .info  (info)
   );

   logic              automatic_mode, out_free, single;
   logic [1:0]        grp;
   logic [POS_W-1:0]  p;
   logic [FILL_W-1:0] th_kanji, th_alnum, th_num, th_num_a, th_an_num, th_ia, th_in, th_ina;
   logic              sw;
   logic [1:0]        nm, im, single_mode, forced_mode;
   logic              forced_ok;
   logic              run_scan;
   state_type         scan_next;

   assign automatic_mode = (override_ff == OVR_AUTO) || (override_ff > OVR_KANJI);
   assign out_free       = !rv_ff || !rsp_stall;
   assign req_stall      = (state_ff != ST_IDLE);
   assign grp            = (version_ff >= 6'd27) ? 2'd2 : ((version_ff >= 6'd10) ? 2'd1 : 2'd0);
   assign p              = pos_ff - POS_W'(fill_ff);
   assign single         = (seen_ff != 4'd0) && $onehot(seen_ff);

   always_comb begin
      unique case (grp)
         2'd0: begin
            th_kanji = 5'd9;  th_alnum = 5'd11; th_num = 5'd6; th_num_a = 5'd6;
            th_an_num = 5'd13; th_ia = 5'd6; th_in = 5'd4; th_ina = 5'd7;
         end
         2'd1: begin
            th_kanji = 5'd12; th_alnum = 5'd15; th_num = 5'd8; th_num_a = 5'd7;
            th_an_num = 5'd15; th_ia = 5'd7; th_in = 5'd4; th_ina = 5'd8;
         end
         default: begin
            th_kanji = 5'd13; th_alnum = 5'd16; th_num = 5'd9; th_num_a = 5'd8;
            th_an_num = 5'd17; th_ia = 5'd8; th_in = 5'd5; th_ina = 5'd9;
         end
      endcase
   end

   always_comb begin
      sw = 1'b0;
      nm = mode_ff;
      if (mode_ff == M_NUM) begin
         if (info.k0 != M_NUM) begin
            sw = 1'b1; nm = info.k0;
         end
      end else if (mode_ff == M_ALNUM) begin
         if (info.k0 == M_KANJI || info.k0 == M_BYTE) begin
            sw = 1'b1; nm = info.k0;
         end
         if (info.run_num >= th_an_num) begin
            sw = 1'b1; nm = M_NUM;
         end
      end else begin
         if (mode_ff == M_BYTE && info.run_kanji >= th_kanji) begin
            sw = 1'b1; nm = M_KANJI;
         end
         if (info.run_alnum >= th_alnum) begin
            sw = 1'b1; nm = M_ALNUM;
         end
         if (!sw && (info.run_num >= th_num ||
                     (info.run_num >= th_num_a && info.kt_num == M_ALNUM))) begin
            sw = 1'b1; nm = M_NUM;
         end
      end
   end

   always_comb begin
      priority if (info.k0 == M_BYTE) begin
         im = M_BYTE;
      end else if (info.k0 == M_KANJI) begin
         im = (info.k1 == M_NUM || info.k1 == M_ALNUM) ? M_KANJI : M_BYTE;
      end else if (info.k0 == M_ALNUM) begin
         im = (info.run_alnum < th_ia &&
               (info.kt_alnum == M_BYTE || info.kt_alnum == M_KANJI)) ? M_BYTE : M_ALNUM;
      end else if (info.run_num < th_in &&
                   (info.kt_num == M_BYTE || info.kt_num == M_KANJI)) begin
         im = M_BYTE;
      end else if (info.run_num < th_ina && info.kt_num == M_ALNUM) begin
         im = M_ALNUM;
      end else begin
         im = M_NUM;
      end
   end

   always_comb begin
      priority if (seen_ff == 4'b0001) single_mode = M_NUM;
      else if (seen_ff == 4'b0010) single_mode = M_ALNUM;
      else if (seen_ff == 4'b0100) single_mode = M_BYTE;
      else single_mode = M_KANJI;

      priority if (override_ff == OVR_NUM) forced_ok = (seen_ff == 4'b0001);
      else if (override_ff == OVR_ALNUM) forced_ok = (seen_ff[3:2] == 2'b00);
      else if (override_ff == OVR_BYTE) forced_ok = !seen_ff[3];
      else forced_ok = 1'b1;

      priority if (override_ff == OVR_NUM || seen_ff == 4'b0001) forced_mode = M_NUM;
      else if (override_ff == OVR_ALNUM || seen_ff == 4'b0010) forced_mode = M_ALNUM;
      else if (override_ff == OVR_KANJI || seen_ff == 4'b1000) forced_mode = M_KANJI;
      else forced_mode = M_BYTE;
   end

   always_comb begin
      state_in  = state_ff;
      fin_in    = fin_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      begin_in  = begin_ff;
      mode_in   = mode_ff;
      seen_in   = seen_ff;
      chosen_in = chosen_ff;
      ctl       = '0;
      run_scan  = 1'b0;
      scan_next = ST_IDLE;
      rv_in = rv_ff && rsp_stall;
      rs_in = rs_ff; re_in = re_ff; rm_in = rm_ff; rb_in = rb_ff; rl_in = rl_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in   = req_is_final;
               state_in = ST_PROC;
               if (pos_ff < POS_W'(MAX_LEN)) begin
                  ctl.load      = 1'b1;
                  ctl.load_idx  = fill_ff;
                  ctl.load_char = req_character;
                  fill_in       = fill_ff + 1'b1;
                  pos_in        = pos_ff + 1'b1;
                  seen_in       = seen_ff | (4'b0001 << class_of(req_character));
               end
            end
         end
         ST_PROC: begin
            if (!fin_ff) begin
               if (fill_ff >= FILL_W'(WIN)) begin
                  if (!automatic_mode) begin
                     ctl.shift = 1'b1;
                     fill_in   = fill_ff - 1'b1;
                     state_in  = ST_IDLE;
                  end else if (chosen_ff) begin
                     run_scan  = 1'b1;
                     scan_next = ST_IDLE;
                  end else begin
                     state_in = ST_INIT;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!automatic_mode || single) begin
               if (out_free) begin
                  rv_in = 1'b1;
                  rs_in = 14'(0);
                  re_in = pos_ff;
                  rl_in = 1'b1;
                  if (!automatic_mode) begin
                     rb_in = !forced_ok;
                     rm_in = forced_ok ? forced_mode : M_NUM;
                  end else begin
                     rb_in = 1'b0;
                     rm_in = single_mode;
                  end
                  ctl.clear = 1'b1;
                  fill_in = '0; pos_in = '0; begin_in = '0; mode_in = M_NUM;
                  seen_in = '0; chosen_in = 1'b0; fin_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else if (!chosen_ff) begin
               state_in = ST_INIT;
            end else begin
               state_in = (fill_ff != '0) ? ST_SCAN : ST_FINAL;
            end
         end
         ST_INIT: begin
            mode_in   = im;
            chosen_in = 1'b1;
            state_in  = (fill_ff != '0) ? ST_SCAN : ST_FINAL;
         end
         ST_SCAN: begin
            run_scan  = 1'b1;
            scan_next = !fin_ff ? ST_IDLE : ((fill_ff == FILL_W'(1)) ? ST_FINAL : ST_SCAN);
         end
         ST_FINAL: begin
            if (out_free) begin
               rv_in = 1'b1;
               rs_in = begin_ff; re_in = pos_ff; rm_in = mode_ff; rb_in = 1'b0; rl_in = 1'b1;
               ctl.clear = 1'b1;
               fill_in = '0; pos_in = '0; begin_in = '0; mode_in = M_NUM;
               seen_in = '0; chosen_in = 1'b0; fin_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (run_scan && !(sw && p > begin_ff && !out_free)) begin
         if (sw && p > begin_ff) begin
            rv_in = 1'b1;
            rs_in = begin_ff; re_in = p; rm_in = mode_ff; rb_in = 1'b0; rl_in = 1'b0;
         end
         if (sw) begin
            begin_in = p;
            mode_in  = nm;
         end
         ctl.shift = 1'b1;
         fill_in   = fill_ff - 1'b1;
         state_in  = scan_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fin_ff      <= 1'b0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         begin_ff    <= '0;
         mode_ff     <= M_NUM;
         seen_ff     <= '0;
         chosen_ff   <= 1'b0;
         version_ff  <= 6'd1;
         override_ff <= OVR_AUTO;
         rv_ff       <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fin_ff    <= fin_in;
         fill_ff   <= fill_in;
         pos_ff    <= pos_in;
         begin_ff  <= begin_in;
         mode_ff   <= mode_in;
         seen_ff   <= seen_in;
         chosen_ff <= chosen_in;
         rv_ff     <= rv_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_VERSION:  version_ff  <= csr_wdata;
               REG_OVERRIDE: override_ff <= csr_wdata[2:0];
               default:      version_ff  <= version_ff;
            endcase
         end
      end
      rs_ff <= rs_in;
      re_ff <= re_in;
      rm_ff <= rm_in;
      rb_ff <= rb_in;
      rl_ff <= rl_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_seg_start    = rs_ff;
   assign rsp_seg_end      = re_ff;
   assign rsp_seg_mode     = rm_ff;
   assign rsp_bad_override = rb_ff;
   assign rsp_seg_last     = rl_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN)) else $error("window fill exceeds its depth");
   a_begin_bound: assert property (@(posedge clock) disable iff (reset)
      begin_ff <= pos_ff) else $error("segment begins past the current position");
   a_bad_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rb_ff |-> rl_ff) else $error("override error beat is not the last");
   a_scan_chosen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> chosen_ff) else $error("scan before the initial mode is set");
`endif

endmodule

// ----- tb/sv/qr_mode_segmenter_tb.sv -----
// Self-checking testbench for the QR mode segmenter, with a segment predictor and scoreboard.
`timescale 1ns / 1ps
module qr_mode_segmenter_tb;
   import qrms_pkg::*;

   typedef struct {
      int unsigned seg_start;
      int unsigned seg_end;
      int unsigned seg_mode;
      int unsigned bad;
      int unsigned last;
   } segment_type;

   class segment_scoreboard;
      bit [15:0]   window [WIN];
      int unsigned fill, cur_mode, seg_begin, position;
      bit [3:0]    seen;
      bit          chosen;
      int unsigned version, forced_code;
      segment_type pending [$];
      int          errors;

      function new();
         version = 1;
         forced_code = OVR_AUTO;
         clear_string();
      endfunction

      function void clear_string();
         foreach (window[i]) window[i] = '0;
         fill = 0; cur_mode = M_NUM; seg_begin = 0; position = 0; seen = '0; chosen = 0;
      endfunction

      function int unsigned char_class(bit [15:0] c);
         bit [7:0] hi, lo;
         bit       t1, t2, l1, l2;
         hi = c[15:8];
         lo = c[7:0];
         if (c >= 16'h30 && c <= 16'h39) return M_NUM;
         if (c == 16'h20 || c == 16'h24 || c == 16'h25 || c == 16'h2A || c == 16'h2B ||
             c == 16'h3A || (c >= 16'h2D && c <= 16'h2F) || (c >= 16'h41 && c <= 16'h5A))
            return M_ALNUM;
         t1 = (lo inside {[8'h40:8'h7E], [8'h80:8'hFC]});
         t2 = (lo inside {[8'h40:8'h7E], [8'h80:8'hBF]});
         l1 = (hi inside {[8'hE0:8'hEA], [8'h81:8'h9F]});
         l2 = (hi inside {[8'hEA:8'hEB]});
         if ((l1 && t1) || (l2 && t2)) return M_KANJI;
         return M_BYTE;
      endfunction

      function int unsigned peek(int unsigned i);
         return char_class(i < fill ? window[i] : 16'h0);
      endfunction

      function int unsigned run_len(int unsigned k, int unsigned from);
         int unsigned j;
         j = from;
         while (j < fill && char_class(window[j]) == k) j++;
         return j - from;
      endfunction

      function int unsigned group();
         return version >= 27 ? 2 : (version >= 10 ? 1 : 0);
      endfunction

      function void push(int unsigned s, int unsigned e, int unsigned m, int unsigned b,
                         int unsigned l);
         segment_type r;
         r.seg_start = s & 14'h3FFF;
         r.seg_end = e & 14'h3FFF;
         r.seg_mode = m & 3;
         r.bad = b;
         r.last = l;
         pending = {pending, r};
      endfunction

      function int unsigned opening_mode();
         int unsigned r, k0, t, kt;
         r = group();
         k0 = peek(0);
         if (k0 == M_BYTE) return M_BYTE;
         if (k0 == M_KANJI) return (peek(1) == M_NUM || peek(1) == M_ALNUM) ? M_KANJI : M_BYTE;
         if (k0 == M_ALNUM) begin
            t = run_len(M_ALNUM, 0);
            kt = peek(t);
            if (t < 6 + r && (kt == M_BYTE || kt == M_KANJI)) return M_BYTE;
            return M_ALNUM;
         end
         t = run_len(M_NUM, 0);
         kt = peek(t);
         if (t < (r == 2 ? 5 : 4) && (kt == M_BYTE || kt == M_KANJI)) return M_BYTE;
         if (t < 7 + r && kt == M_ALNUM) return M_ALNUM;
         return M_NUM;
      endfunction

      function void drop_head();
         if (fill == 0) return;
         for (int i = 0; i + 1 < fill; i++) window[i] = window[i + 1];
         fill--;
      endfunction

      function void decide_head();
         int unsigned r, p, prev, nm, k, t;
         bit sw;
         r = group();
         p = position - fill;
         prev = cur_mode;
         nm = prev;
         k = peek(0);
         sw = 0;
         if (prev == M_NUM) begin
            if (k != M_NUM) begin sw = 1; nm = k; end
         end else if (prev == M_ALNUM) begin
            if (k == M_KANJI || k == M_BYTE) begin sw = 1; nm = k; end
            if (run_len(M_NUM, 0) >= 13 + 2 * r) begin sw = 1; nm = M_NUM; end
         end else begin
            if (prev == M_BYTE && run_len(M_KANJI, 0) >= 9 + ((3 * r < 4) ? 3 * r : 4)) begin
               sw = 1; nm = M_KANJI;
            end
            if (run_len(M_ALNUM, 0) >= 11 + ((4 * r < 5) ? 4 * r : 5)) begin
               sw = 1; nm = M_ALNUM;
            end
            if (!sw) begin
               t = run_len(M_NUM, 0);
               if (t >= 6 + ((2 * r < 3) ? 2 * r : 3) || (t >= 6 + r && peek(t) == M_ALNUM)) begin
                  sw = 1; nm = M_NUM;
               end
            end
         end
         if (sw) begin
            if (p > seg_begin) push(seg_begin, p, prev, 0, 0);
            seg_begin = p;
            cur_mode = nm;
         end
         drop_head();
      endfunction

      function void note_character(bit [15:0] ch, bit fin);
         bit          automatic_mode, single, ok;
         int unsigned m;
         automatic_mode = forced_code == OVR_AUTO || forced_code > OVR_KANJI;
         if (position < MAX_LEN) begin
            if (fill >= WIN) drop_head();
            seen[char_class(ch)] = 1;
            window[fill] = ch;
            fill++;
            position++;
         end
         if (!fin) begin
            if (fill >= WIN) begin
               if (automatic_mode) begin
                  if (!chosen) begin cur_mode = opening_mode(); chosen = 1; end
                  decide_head();
               end else begin
                  drop_head();
               end
            end
            return;
         end
         single = seen != 0 && (seen & (seen - 1)) == 0;
         if (!automatic_mode) begin
            case (forced_code)
               OVR_NUM:   ok = seen == 4'b0001;
               OVR_ALNUM: ok = (seen & 4'b1100) == 0;
               OVR_BYTE:  ok = !seen[M_KANJI];
               default:   ok = 1;
            endcase
            if (!ok) begin
               push(0, position, M_NUM, 1, 1);
            end else begin
               if (forced_code == OVR_NUM || seen == 4'b0001) m = M_NUM;
               else if (forced_code == OVR_ALNUM || seen == 4'b0010) m = M_ALNUM;
               else if (forced_code == OVR_KANJI || seen == 4'b1000) m = M_KANJI;
               else m = M_BYTE;
               push(0, position, m, 0, 1);
            end
         end else if (single) begin
            m = seen[M_NUM] ? M_NUM : seen[M_ALNUM] ? M_ALNUM : seen[M_BYTE] ? M_BYTE : M_KANJI;
            push(0, position, m, 0, 1);
         end else begin
            if (!chosen) begin cur_mode = opening_mode(); chosen = 1; end
            while (fill > 0) decide_head();
            push(seg_begin, position, cur_mode, 0, 1);
         end
         clear_string();
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("mismatch: %s got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_segment(int unsigned s, int unsigned e, int unsigned m,
                         int unsigned b, int unsigned l);
         segment_type w;
         if (pending.size() == 0) begin
            report("unexpected segment, start", s, 0);
            return;
         end
         w = pending.pop_front();
         if (s != w.seg_start) report("seg_start", s, w.seg_start);
         if (e != w.seg_end) report("seg_end", e, w.seg_end);
         if (m != w.seg_mode) report("seg_mode", m, w.seg_mode);
         if (b != w.bad) report("bad_override", b, w.bad);
         if (l != w.last) report("seg_last", l, w.last);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = 0;
   logic [5:0]  csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [15:0] req_character = '0;
   logic        req_is_final = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [13:0] rsp_seg_start, rsp_seg_end;
   logic [1:0]  rsp_seg_mode;
   logic        rsp_bad_override, rsp_seg_last;

   localparam int WATCHDOG_LIMIT = 3000;

   segment_scoreboard board = new();
   bit          calm = 0;
   int          sent = 0;
   int          quiet_cycles = 0;
   logic [15:0] alnum_codes [45];

   qr_mode_segmenter DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int draw_gap();
      return calm ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : $urandom_range(0, 2));
   endfunction

   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = draw_gap();
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
         board.check_segment(rsp_seg_start, rsp_seg_end, rsp_seg_mode, rsp_bad_override,
                             rsp_seg_last);
      end
   end

   task automatic send_character(input logic [15:0] ch, input logic fin);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_character <= ch;
      req_is_final <= fin;
      do @(posedge clock); while (req_stall);
      board.note_character(ch, fin);
      sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int unsigned value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value[5:0];
      @(posedge clock);
      if (idx == REG_VERSION) board.version = value & 6'h3F;
      else board.forced_code = value & 3'h7;
   endtask

   task automatic configure(input int unsigned ver, input int unsigned ovr);
      wait_idle();
      write_reg(REG_VERSION, ver);
      write_reg(REG_OVERRIDE, ovr);
      csr_we <= 0;
   endtask

   function automatic logic [15:0] make_character(input int unsigned kind);
      logic [7:0] lead;
      case (kind)
         M_NUM:   return 16'(16'h30 + $urandom_range(0, 9));
         M_ALNUM: return alnum_codes[$urandom_range(0, 44)];
         M_KANJI: begin
            lead = $urandom_range(0, 2) == 0 ? 8'($urandom_range(8'hE0, 8'hEB))
                                             : 8'($urandom_range(8'h81, 8'h9F));
            if (lead >= 8'hEA || $urandom_range(0, 1) == 0)
               return {lead, $urandom_range(0, 1) ? 8'($urandom_range(8'h40, 8'h7E))
                                                  : 8'($urandom_range(8'h80, 8'hBF))};
            return {lead, 8'($urandom_range(8'h80, 8'hFC))};
         end
         default: return $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom());
      endcase
   endfunction

   task automatic send_string(input int unsigned len, input int unsigned kinds);
      int unsigned run, kind;
      run = 0;
      kind = M_NUM;
      for (int unsigned i = 0; i < len; i++) begin
         if (run == 0) begin
            kind = kinds == 4 ? $urandom_range(0, 3) : kinds;
            run = $urandom_range(1, 16);
         end
         run--;
         send_character(make_character(kind), i + 1 == len);
      end
   endtask

   initial begin
      string alnum_text;
      alnum_text = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
      foreach (alnum_codes[i]) alnum_codes[i] = 16'(alnum_text[i]);
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Single characters at the code extremes, a short mixed string, then a two-character string per override code.
      configure(1, OVR_AUTO);
      send_character(16'h0000, 1);
      send_character(16'hFFFF, 1);
      send_character(16'h8140, 1);
      send_character(16'h0039, 0);
      send_character(16'h0041, 0);
      send_character(16'h00E9, 1);
      for (int unsigned ovr = OVR_NUM; ovr <= 7; ovr++) begin
         configure(ovr == OVR_KANJI ? 63 : 0, ovr);
         send_character(16'h0031, 0);
         send_character(ovr[0] ? 16'h0041 : 16'hEB40, 1);
      end
      configure(40, OVR_AUTO);
      send_string(24, 4);

      while (sent < 250) begin
         case ($urandom_range(0, 9))
            0: configure($urandom_range(0, 63), $urandom_range(0, 7));
            1: configure($urandom_range(0, 1) ? 9 : 26, OVR_AUTO);
            2: configure($urandom_range(0, 1) ? 10 : 27, OVR_AUTO);
            3: configure($urandom_range(0, 40), OVR_AUTO);
            default: ;
         endcase
         calm = $urandom_range(0, 5) == 0;
         send_string($urandom_range(0, 7) == 0 ? $urandom_range(20, 45) : $urandom_range(1, 30),
                     $urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : 4);
      end
      calm = 0;

      wait_idle();
      if (board.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
